@@ hdl/pen_drawing_command_parser_unit_assert.svh @@
// Assertion macros for the pen drawing command parser.
`ifndef PEN_DRAWING_COMMAND_PARSER_UNIT_ASSERT_SVH
`define PEN_DRAWING_COMMAND_PARSER_UNIT_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define PDCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define PDCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/pdcp_pkg.sv @@
// Types and constants of the pen drawing command parser.
`default_nettype none
package pdcp_pkg;
  typedef enum logic [3:0] {
    PH_VERB, PH_MOVE_ID, PH_MOVE_DX, PH_MOVE_DY, PH_MOVE_COLOR, PH_MOVE_RET,
    PH_MOVE_RUN, PH_PENS_RUN, PH_PEN_ID, PH_PEN_RUN, PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    RS_PIXEL, RS_PEN_POS, RS_PEN_CNT, RS_SIZE, RS_CLOSED
  } rsrc_e;

  localparam logic [2:0] KIND_PIXEL   = 3'd0;
  localparam logic [2:0] KIND_PEN_POS = 3'd1;
  localparam logic [2:0] KIND_PEN_CNT = 3'd2;
  localparam logic [2:0] KIND_SIZE    = 3'd3;
  localparam logic [2:0] KIND_CLOSED  = 3'd4;

  localparam logic [31:0] VERB_MOVE = 32'h4d4f5645;
  localparam logic [31:0] VERB_PENS = 32'h50454e53;
  localparam logic [31:0] VERB_PEN  = 32'h0050454e;
  localparam logic [31:0] VERB_SIZE = 32'h53495a45;

  localparam int unsigned OUT_DW = 72;

  typedef struct packed {
    logic        last_of_run;
    logic [31:0] pixel_value;
    logic [12:0] pos_y;
    logic [12:0] pos_x;
    logic [4:0]  pen_number;
    logic [2:0]  kind;
  } result_t;
endpackage
`default_nettype wire

@@ hdl/pen_drawing_command_parser_unit.sv @@
// Pen drawing command parser: byte stream in, pixel writes and reports out.
//
// Slave stream carries one client byte per transaction; the parser takes a
// byte every cycle while s_axis_tready is high. Master stream carries result
// transactions (pixel write, pen position, pen count, canvas size, stream
// closed); tlast marks the final result caused by one byte.
// A result reaches m_axis through the stage-2 registers, loaded together with
// the pen table read, and then through the result queue.
// Throughput: one byte per cycle while s_axis_tready is high; set by the
// one pen table read-modify-write per command and the 8-entry result queue.
// When the receiver stalls, results collect in the queue and s_axis_tready
// drops once fewer than four free slots remain. Reset: all pens at origin
// (per-entry valid bits), parser waits for a verb, stream open, canvas
// 1024 x 768. The user must write canvas registers via cfg_we_i / cfg_idx_i /
// cfg_data_i only while no traffic is in flight; the block has no check.
`default_nettype none
module pen_drawing_command_parser_unit import pdcp_pkg::*; #(
  parameter int unsigned PEN_COUNT     = 16,
  parameter int unsigned GARBAGE_LIMIT = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [12:0]       cfg_data_i,
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [2:0] kind, [7:3] pen_number, [20:8] pos_x, [33:21] pos_y,
  // [65:34] pixel_value, [71:66] zero
  output      logic [OUT_DW-1:0] m_axis_tdata,
  output      logic              m_axis_tlast    // last_of_run
);
  localparam int unsigned ID_W = (PEN_COUNT > 1) ? $clog2(PEN_COUNT) : 1;
  localparam logic [31:0] PEN_CNT32 = 32'(PEN_COUNT);
  localparam logic [5:0]  GLIM = 6'(GARBAGE_LIMIT);

  // ---------------- configuration
  logic [12:0] width_q, height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd768;
    end else if (cfg_we_i) begin
      if (cfg_idx_i) height_q <= cfg_data_i;
      else           width_q  <= cfg_data_i;
    end
  end

  // ---------------- parser state
  phase_e          phase_q, phase_d;
  logic [31:0]     acc_q, acc_d;
  logic [5:0]      len_q, len_d;
  logic            id_ok_q, id_ok_d;
  logic [ID_W-1:0] id_q, id_d;
  logic            dx_up_q, dx_up_d, dx_dn_q, dx_dn_d;
  logic            dy_up_q, dy_up_d, dy_dn_q, dy_dn_d;
  logic [31:0]     color_q, color_d;
  logic            closed_q, closed_d;

  logic            s2_valid_q, s2_valid_d;
  rsrc_e           s2_src_q, s2_src_d;
  logic            s2_ret_q, s2_ret_d;

  logic        acc_ok;
  logic [7:0]  c, lc;
  logic        ws, nl;
  phase_e      ph;
  logic [31:0] a;
  logic [5:0]  l;
  logic        fire;

  assign fire = s_axis_tvalid && s_axis_tready;
  assign c    = s_axis_tdata;
  assign ws   = (c == 8'h20) || (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09);
  assign nl   = (c == 8'h0a) || (c == 8'h0d);
  assign lc   = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  assign acc_ok = acc_q < PEN_CNT32;

  always_comb begin
    phase_d = phase_q;  acc_d = acc_q;  len_d = len_q;
    id_ok_d = id_ok_q;  id_d = id_q;    color_d = color_q;
    dx_up_d = dx_up_q;  dx_dn_d = dx_dn_q;
    dy_up_d = dy_up_q;  dy_dn_d = dy_dn_q;
    closed_d = closed_q;
    s2_valid_d = 1'b0;  s2_src_d = s2_src_q;  s2_ret_d = s2_ret_q;
    ph = phase_q;  a = acc_q;  l = len_q;
    if (fire && !closed_q) begin
      if (!ws) begin
        if (ph == PH_MOVE_RUN || ph == PH_PENS_RUN || ph == PH_PEN_RUN) begin
          ph = PH_VERB; a = '0; l = '0;
        end
        if (ph != PH_SKIP) begin
          if (l >= GLIM) begin
            if (ph == PH_VERB) begin
              closed_d   = 1'b1;
              s2_valid_d = 1'b1;
              s2_src_d   = RS_CLOSED;
            end else begin
              phase_d = PH_SKIP; acc_d = '0; len_d = '0;
            end
          end else begin
            unique case (ph)
              PH_VERB:              a = {a[23:0], c};
              PH_MOVE_ID, PH_PEN_ID:
                a = {a[28:0], 3'b0} + {a[30:0], 1'b0} + 32'(c) - 32'd48;
              PH_MOVE_COLOR:
                a = {a[27:0], 4'b0} + 32'(lc) - ((lc >= 8'h61) ? 32'd87 : 32'd48);
              default: begin
                if (l == 6'd0)
                  a = (c == 8'h31) ? 32'd1 : (c == 8'h2d) ? 32'd2 : 32'd0;
                else if (l == 6'd1 && a == 32'd2)
                  a = (c == 8'h31) ? 32'd3 : 32'd0;
              end
            endcase
            len_d   = (l < 6'd63) ? l + 6'd1 : l;
            acc_d   = a;
            phase_d = ph;
          end
        end
      end else if (ph == PH_SKIP) begin
        phase_d = PH_VERB; len_d = '0; acc_d = '0;
      end else begin
        if (l != 6'd0) begin
          len_d = '0;
          acc_d = '0;
          unique case (ph)
            PH_VERB: begin
              if (l == 6'd4 && a == VERB_MOVE)      ph = PH_MOVE_ID;
              else if (l == 6'd4 && a == VERB_PENS) ph = PH_PENS_RUN;
              else if (l == 6'd3 && a == VERB_PEN)  ph = PH_PEN_ID;
              else if (l == 6'd4 && a == VERB_SIZE) begin
                s2_valid_d = 1'b1;
                s2_src_d   = RS_SIZE;
              end
            end
            PH_MOVE_ID, PH_PEN_ID: begin
              id_ok_d = acc_ok;
              id_d    = acc_ok ? acc_q[ID_W-1:0] : '0;
              ph      = (ph == PH_MOVE_ID) ? PH_MOVE_DX : PH_PEN_RUN;
            end
            PH_MOVE_DX: begin
              dx_up_d = a == 32'd1; dx_dn_d = a == 32'd3; ph = PH_MOVE_DY;
            end
            PH_MOVE_DY: begin
              dy_up_d = a == 32'd1; dy_dn_d = a == 32'd3; ph = PH_MOVE_COLOR;
            end
            PH_MOVE_COLOR: begin
              color_d = a; ph = PH_MOVE_RET;
            end
            PH_MOVE_RET: begin
              acc_d = a; ph = PH_MOVE_RUN;
            end
            default: ;
          endcase
          phase_d = ph;
        end
        if (nl && (ph == PH_MOVE_RUN || ph == PH_PENS_RUN || ph == PH_PEN_RUN)) begin
          if (ph == PH_PENS_RUN) begin
            s2_valid_d = 1'b1; s2_src_d = RS_PEN_CNT;
          end else if (id_ok_d) begin
            s2_valid_d = 1'b1;
            s2_src_d   = (ph == PH_PEN_RUN) ? RS_PEN_POS : RS_PIXEL;
            s2_ret_d   = acc_d == 32'd1;
          end
          phase_d = PH_VERB;
          acc_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERB;  acc_q <= '0;  len_q <= '0;
      id_ok_q <= 1'b0;     id_q <= '0;   color_q <= '0;
      dx_up_q <= 1'b0; dx_dn_q <= 1'b0; dy_up_q <= 1'b0; dy_dn_q <= 1'b0;
      closed_q <= 1'b0;
      s2_valid_q <= 1'b0; s2_src_q <= RS_PIXEL; s2_ret_q <= 1'b0;
    end else begin
      phase_q <= phase_d;  acc_q <= acc_d;  len_q <= len_d;
      id_ok_q <= id_ok_d;  id_q <= id_d;    color_q <= color_d;
      dx_up_q <= dx_up_d; dx_dn_q <= dx_dn_d; dy_up_q <= dy_up_d; dy_dn_q <= dy_dn_d;
      closed_q <= closed_d;
      s2_valid_q <= s2_valid_d; s2_src_q <= s2_src_d; s2_ret_q <= s2_ret_d;
    end
  end

  // stage 2 command fields, captured with the table read
  logic [ID_W-1:0] s2_id_q;
  logic            s2_dxu_q, s2_dxd_q, s2_dyu_q, s2_dyd_q;
  logic [31:0]     s2_color_q;
  always_ff @(posedge clk_i) begin
    s2_id_q <= id_d;  s2_color_q <= color_d;
    s2_dxu_q <= dx_up_d; s2_dxd_q <= dx_dn_d;
    s2_dyu_q <= dy_up_d; s2_dyd_q <= dy_dn_d;
  end

  // ---------------- pen position table
  logic [23:0]          pen_mem [PEN_COUNT];
  logic [PEN_COUNT-1:0] pen_vld_q;
  logic                 mem_we;
  logic [23:0]          mem_wd, rd_q, fwd_q, old_pos;
  logic                 rd_vld_q, fwd_hit_q, hit;

  assign hit = mem_we && (s2_id_q == id_d);

  always_ff @(posedge clk_i) begin
    if (mem_we) pen_mem[s2_id_q] <= mem_wd;
    rd_q  <= pen_mem[id_d];
    fwd_q <= mem_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_vld_q <= '0; rd_vld_q <= 1'b0; fwd_hit_q <= 1'b0;
    end else begin
      if (mem_we) pen_vld_q[s2_id_q] <= 1'b1;
      rd_vld_q  <= pen_vld_q[id_d];
      fwd_hit_q <= hit;
    end
  end

  assign old_pos = fwd_hit_q ? fwd_q : (rd_vld_q ? rd_q : '0);

  logic [11:0] ox, oy, nx, ny;
  assign ox = old_pos[11:0];
  assign oy = old_pos[23:12];
  always_comb begin
    nx = ox;
    ny = oy;
    if (s2_dxu_q && ({1'b0, ox} + 13'd1 < width_q) && ox != 12'hfff) nx = ox + 12'd1;
    else if (s2_dxd_q && ox != 12'd0) nx = ox - 12'd1;
    if (s2_dyu_q && ({1'b0, oy} + 13'd1 < height_q) && oy != 12'hfff) ny = oy + 12'd1;
    else if (s2_dyd_q && oy != 12'd0) ny = oy - 12'd1;
  end
  assign mem_we = s2_valid_q && s2_src_q == RS_PIXEL;
  assign mem_wd = {ny, nx};

  // ---------------- result build
  result_t r0, r1;
  logic [1:0] push_n;
  logic [4:0] pen5;
  assign pen5 = 5'(32'(s2_id_q));
  always_comb begin
    r0 = '0;
    r1 = '0;
    push_n = 2'd0;
    if (s2_valid_q) begin
      push_n = 2'd1;
      r0.last_of_run = 1'b1;
      unique case (s2_src_q)
        RS_PIXEL: begin
          r0.kind = KIND_PIXEL; r0.pen_number = pen5;
          r0.pos_x = {1'b0, ox}; r0.pos_y = {1'b0, oy};
          r0.pixel_value = {s2_color_q[23:0], 8'hff};
          if (s2_ret_q) begin
            push_n = 2'd2;
            r0.last_of_run = 1'b0;
            r1.kind = KIND_PEN_POS; r1.pen_number = pen5;
            r1.pos_x = {1'b0, nx}; r1.pos_y = {1'b0, ny};
            r1.last_of_run = 1'b1;
          end
        end
        RS_PEN_POS: begin
          r0.kind = KIND_PEN_POS; r0.pen_number = pen5;
          r0.pos_x = {1'b0, ox}; r0.pos_y = {1'b0, oy};
        end
        RS_PEN_CNT: begin
          r0.kind = KIND_PEN_CNT; r0.pen_number = PEN_CNT32[4:0];
        end
        RS_SIZE: begin
          r0.kind = KIND_SIZE; r0.pos_x = width_q; r0.pos_y = height_q;
        end
        default: r0.kind = KIND_CLOSED;
      endcase
    end
  end

  // ---------------- result queue
  result_t    q_mem [8];
  logic [2:0] wp_q, rp_q;
  logic [3:0] cnt_q;
  logic       pop;
  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) q_mem[wp_q] <= r0;
    if (push_n == 2'd2) q_mem[wp_q + 3'd1] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + 3'(push_n);
      rp_q  <= rp_q + 3'(pop);
      cnt_q <= cnt_q + 4'(push_n) - 4'(pop);
    end
  end

  result_t head;
  assign head          = q_mem[rp_q];
  assign m_axis_tvalid = cnt_q != 4'd0;
  assign m_axis_tdata  = {6'd0, head.pixel_value, head.pos_y, head.pos_x,
                          head.pen_number, head.kind};
  assign m_axis_tlast  = head.last_of_run;
  assign s_axis_tready = (cnt_q + (s2_valid_q ? 4'd2 : 4'd0)) <= 4'd4;

  // ---------------- checks
  `include "pen_drawing_command_parser_unit_assert.svh"
  `PDCP_ASSERT_IMP(a_queue_bound, 1'b1, cnt_q <= 4'd8, "result queue overflow")
  `PDCP_ASSERT_NXT(a_closed_sticky, closed_q, closed_q, "closed stream reopened")
  `PDCP_ASSERT_NXT(a_s2_from_accept, !fire, !s2_valid_q, "result without accepted byte")
  `PDCP_ASSERT_IMP(a_wr_vs_rd, mem_we && fire, !s2_valid_d,
                   "pen table write collides with new command")
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the pen drawing command parser unit.
`default_nettype none
module tb;
  import pdcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPENS = 16;
  localparam int unsigned TOKEN_MAX = 32;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  class draw_scoreboard;
    logic [12:0] canvas_w, canvas_h;
    logic [11:0] pen_x[NPENS], pen_y[NPENS];
    phase_e      phase;
    logic [31:0] acc;
    int unsigned tok_len;
    bit          id_ok, closed;
    int unsigned pen_id;
    int          step_x, step_y;
    logic [31:0] color;
    result_t     expected_q[$];
    int unsigned errors, checked;
    int unsigned kind_seen[8];

    function void reset_state();
      foreach (pen_x[i]) begin
        pen_x[i] = '0;
        pen_y[i] = '0;
      end
      canvas_w = 13'd1024;
      canvas_h = 13'd768;
      phase = PH_VERB;
      acc = '0;
      tok_len = 0;
      id_ok = 0;
      pen_id = 0;
      step_x = 0;
      step_y = 0;
      color = '0;
      closed = 0;
      errors = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_canvas(logic idx, logic [12:0] val);
      if (idx == CFG_WIDTH) canvas_w = val;
      else canvas_h = val;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(logic [2:0] kind, logic [4:0] pen, logic [12:0] x,
                       logic [12:0] y, logic [31:0] pix);
      result_t r;
      r.kind = kind;
      r.pen_number = pen;
      r.pos_x = x;
      r.pos_y = y;
      r.pixel_value = pix;
      r.last_of_run = 1'b0;
      expected_q.push_back(r);
    endfunction

    function int tri_code(logic [31:0] code);
      if (code == 32'd1) return 1;
      if (code == 32'd3) return -1;
      return 0;
    endfunction

    function logic [11:0] step_pos(logic [11:0] p, int d, logic [12:0] lim);
      if (d == 1 && 32'(p) + 1 < 32'(lim) && p < 12'd4095) return p + 12'd1;
      if (d == -1 && p > 0) return p - 12'd1;
      return p;
    endfunction

    function void execute_cmd();
      if (phase == PH_PENS_RUN) begin
        push(KIND_PEN_CNT, 5'(NPENS), '0, '0, '0);
      end else if (phase == PH_PEN_RUN && id_ok) begin
        push(KIND_PEN_POS, 5'(pen_id), 13'(pen_x[pen_id]), 13'(pen_y[pen_id]), '0);
      end else if (phase == PH_MOVE_RUN && id_ok) begin
        push(KIND_PIXEL, 5'(pen_id), 13'(pen_x[pen_id]), 13'(pen_y[pen_id]),
             {color[23:0], 8'hff});
        pen_x[pen_id] = step_pos(pen_x[pen_id], step_x, canvas_w);
        pen_y[pen_id] = step_pos(pen_y[pen_id], step_y, canvas_h);
        if (tri_code(acc) == 1)
          push(KIND_PEN_POS, 5'(pen_id), 13'(pen_x[pen_id]), 13'(pen_y[pen_id]), '0);
      end
      phase = PH_VERB;
      acc = '0;
    endfunction

    // one accepted byte transaction
    function void note_byte(logic [7:0] c);
      bit ws, nl, run_phase;
      int unsigned n0, len;
      logic [31:0] a, lc;
      n0 = expected_q.size();
      ws = (c == 8'h20 || c == 8'h0a || c == 8'h0d || c == 8'h09);
      nl = (c == 8'h0a || c == 8'h0d);
      a = acc;
      if (closed) return;
      run_phase = (phase == PH_MOVE_RUN || phase == PH_PENS_RUN || phase == PH_PEN_RUN);
      if (!ws) begin
        if (run_phase) begin
          phase = PH_VERB;
          a = '0;
          tok_len = 0;
        end
        if (phase == PH_SKIP) return;
        if (tok_len >= TOKEN_MAX) begin
          if (phase == PH_VERB) begin
            closed = 1;
            push(KIND_CLOSED, '0, '0, '0, '0);
            expected_q[$].last_of_run = 1'b1;
            return;
          end
          phase = PH_SKIP;
          acc = '0;
          tok_len = 0;
          return;
        end
        case (phase)
          PH_VERB: a = {a[23:0], c};
          PH_MOVE_ID, PH_PEN_ID: a = a * 10 + 32'(c) - 32'd48;
          PH_MOVE_COLOR: begin
            lc = (c >= "A" && c <= "Z") ? 32'(c) + 32 : 32'(c);
            a = a * 16 + ((lc >= 32'h61) ? lc - 87 : lc - 48);
          end
          default: begin
            if (tok_len == 0) a = (c == "1") ? 32'd1 : (c == "-") ? 32'd2 : 32'd0;
            else if (tok_len == 1 && a == 32'd2) a = (c == "1") ? 32'd3 : 32'd0;
          end
        endcase
        if (tok_len < 63) tok_len++;
        acc = a;
        return;
      end
      if (phase == PH_SKIP) begin
        phase = PH_VERB;
        tok_len = 0;
        acc = '0;
        return;
      end
      if (tok_len > 0) begin
        len = tok_len;
        tok_len = 0;
        acc = '0;
        case (phase)
          PH_VERB: begin
            if (len == 4 && a == VERB_MOVE) phase = PH_MOVE_ID;
            else if (len == 4 && a == VERB_PENS) phase = PH_PENS_RUN;
            else if (len == 3 && a == VERB_PEN) phase = PH_PEN_ID;
            else if (len == 4 && a == VERB_SIZE)
              push(KIND_SIZE, '0, canvas_w, canvas_h, '0);
          end
          PH_MOVE_ID, PH_PEN_ID: begin
            id_ok = a < NPENS;
            pen_id = id_ok ? a : 0;
            phase = (phase == PH_MOVE_ID) ? PH_MOVE_DX : PH_PEN_RUN;
          end
          PH_MOVE_DX: begin
            step_x = tri_code(a);
            phase = PH_MOVE_DY;
          end
          PH_MOVE_DY: begin
            step_y = tri_code(a);
            phase = PH_MOVE_COLOR;
          end
          PH_MOVE_COLOR: begin
            color = a;
            phase = PH_MOVE_RET;
          end
          PH_MOVE_RET: begin
            acc = a;
            phase = PH_MOVE_RUN;
          end
          default: ;
        endcase
      end
      if (nl && (phase == PH_MOVE_RUN || phase == PH_PENS_RUN || phase == PH_PEN_RUN))
        execute_cmd();
      if (expected_q.size() > n0) expected_q[$].last_of_run = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction kind=%0d", got.kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      kind_seen[got.kind]++;
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind);
        errors++;
      end
      if (got.pen_number !== e.pen_number) begin
        $error("pen_number: expected %0d, got %0d", e.pen_number, got.pen_number);
        errors++;
      end
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x: expected %0d, got %0d", e.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y: expected %0d, got %0d", e.pos_y, got.pos_y);
        errors++;
      end
      if (got.pixel_value !== e.pixel_value) begin
        $error("pixel_value: expected %h, got %h", e.pixel_value, got.pixel_value);
        errors++;
      end
      if (got.last_of_run !== e.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", e.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [12:0]       cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  draw_scoreboard sb = new();
  logic [7:0]  byte_q[$];
  bit          hold_long = 0;
  bit          no_gaps = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;

  pen_drawing_command_parser_unit dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'({m_axis_tlast, m_axis_tdata[65:0]});
      sb.check_result(got);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // receiver
  initial begin
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_long = 0;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 4) == 0) stall = gap_len();
      end
    end
  end

  task automatic add_str(string s);
    foreach (s[i]) byte_q.push_back(s[i]);
  endtask

  task automatic add_sep();
    string ws;
    int unsigned k;
    ws = " \t\r\n";
    k = $urandom_range(0, 3);
    repeat (k) byte_q.push_back(ws[$urandom_range(0, 3)]);
    byte_q.push_back($urandom_range(0, 1) ? 8'h0a : 8'h0d);
    if ($urandom_range(0, 3) == 0) byte_q.push_back(" ");
  endtask

  function automatic string step_tok();
    case ($urandom_range(0, 7))
      0, 1: return "1";
      2, 3: return "-1";
      4: return "0";
      5: return "-";
      6: return "1-9";
      default: return "x1";
    endcase
  endfunction

  function automatic string hex_tok();
    string s, digits;
    int unsigned n, k;
    digits = "0123456789abcdefABCDEF";
    s = "";
    n = $urandom_range(1, 8);
    repeat (n) begin
      k = $urandom_range(0, 21);
      s = {s, digits.substr(k, k)};
    end
    return s;
  endfunction

  function automatic string filler(int unsigned n);
    string s;
    s = "";
    repeat (n) s = {s, "7"};
    return s;
  endfunction

  // mostly well-formed commands, some noise and broken ones
  task automatic gen_traffic(int unsigned n_bytes, int unsigned pen_hi);
    int unsigned target, r;
    string id;
    target = byte_q.size() + n_bytes;
    while (byte_q.size() < target) begin
      r = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? $sformatf("%0d", $urandom_range(0, 19))
                                       : $sformatf("%0d", $urandom_range(0, pen_hi));
      if (r < 55) begin
        add_str({"MOVE ", id, " ", step_tok(), " ", step_tok(), " ", hex_tok(), " ",
                 $urandom_range(0, 1) ? "1" : "0"});
        add_sep();
      end else if (r < 65) begin
        add_str({"PEN ", id});
        add_sep();
      end else if (r < 70) begin
        add_str("PENS");
        add_sep();
      end else if (r < 75) begin
        add_str("SIZE ");
      end else if (r < 80) begin
        add_str({"MOVE ", id, " 1 1 ", hex_tok(), " 1 PENS"});
        add_sep();
      end else if (r < 84) begin
        add_str({"MOVE ", id, " 1 ", filler($urandom_range(33, 40)), " ff 1"});
        add_sep();
      end else if (r < 88) begin
        add_str({"PEN ", filler($urandom_range(30, 34)), "\n"});
      end else begin
        repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom_range(0, 255)));
        add_str(" \n");
      end
    end
  endtask

  task automatic send_all();
    int unsigned g;
    while (byte_q.size() > 0) begin
      g = no_gaps ? 0 : gap_len();
      if (g > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= byte_q.pop_front();
      do @(posedge clk_i); while (!s_axis_tready);
      bytes_sent++;
      if ($urandom_range(0, 60) == 0) no_gaps = !no_gaps;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_canvas(logic [12:0] w, logic [12:0] h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= CFG_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_canvas(CFG_WIDTH, w);
    sb.set_canvas(CFG_HEIGHT, h);
    @(posedge clk_i);
  endtask

  initial begin
    sb.reset_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every verb, bad ids, missing newline, skipped tokens
    add_str("SIZE\tPENS\rPEN 0\nMOVE 0 1 1 FfFfFfFf 1\n");
    add_str("MOVE 0 -1 -1 0 0\r\nMOVE 16 1 1 a 1\nPEN 99\n");
    add_str("PENS MOVE 1 1 1 ff 1 SIZE HELLO \x80\xff\x7f\n");
    send_all();
    drain();

    write_canvas(13'd4096, 13'd1);
    hold_long = 1;
    gen_traffic(400, 3);
    send_all();
    drain();

    write_canvas(13'd1, 13'd4096);
    gen_traffic(350, 3);
    send_all();
    drain();

    write_canvas(13'd3, 13'd2);
    gen_traffic(350, 2);
    send_all();
    drain();

    write_canvas(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    gen_traffic(350, 15);
    add_str({"\n", filler(TOKEN_MAX + 1), "PENS\nSIZE \n"});
    send_all();
    drain();

    $display("sent %0d bytes over five canvas settings; checked %0d results", bytes_sent,
             sb.checked);
    $display("pixel %0d, pen pos %0d, pen count %0d, size %0d, closed %0d",
             sb.kind_seen[KIND_PIXEL], sb.kind_seen[KIND_PEN_POS],
             sb.kind_seen[KIND_PEN_CNT], sb.kind_seen[KIND_SIZE],
             sb.kind_seen[KIND_CLOSED]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/pdcp_pkg.sv
hdl/pen_drawing_command_parser_unit.sv
sim/tb.sv
